// ===== design/jsu_pkg.sv =====
// Shared types, character codes and helper functions for the JSON string unescaper.
// No dependencies; used by jsu_decode, jsu_burst and json_string_unescape.
`default_nettype none

package jsu_pkg;

  localparam int MaxResults = 5;
  localparam int CntW       = $clog2(MaxResults + 1);

  typedef enum logic [2:0] {
    MODE_NORMAL = 3'd0,
    MODE_ESC    = 3'd1,
    MODE_U0     = 3'd2,
    MODE_U1     = 3'd3,
    MODE_U2     = 3'd4,
    MODE_U3     = 3'd5
  } mode_t;

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;

  localparam logic [7:0] UTF8_CONT = 8'h80;
  localparam logic [7:0] UTF8_LEAD2 = 8'hC0;
  localparam logic [7:0] UTF8_LEAD3 = 8'hE0;
  localparam logic [5:0] UTF8_MASK = 6'h3F;

  // bytes[0] goes out first
  typedef struct packed {
    logic [MaxResults-1:0][7:0] bytes;
    logic [CntW-1:0]            cnt;
    logic                       fin;
  } burst_t;

  function automatic logic [4:0] hex_decode(input logic [7:0] b);
    logic [4:0] r;
    begin
      r = 5'd0;
      if (b >= 8'h30 && b <= 8'h39) begin
        r = {1'b1, 4'(b - 8'h30)};
      end else if (b >= 8'h61 && b <= 8'h66) begin
        r = {1'b1, 4'(b - 8'h57)};
      end else if (b >= 8'h41 && b <= 8'h46) begin
        r = {1'b1, 4'(b - 8'h37)};
      end
      return r;
    end
  endfunction

  function automatic logic [7:0] map_escape(input logic [7:0] b);
    logic [7:0] r;
    begin
      case (b)
        CH_N:    r = 8'h0A;
        CH_T:    r = 8'h09;
        CH_R:    r = 8'h0D;
        CH_B:    r = 8'h08;
        CH_F:    r = 8'h0C;
        default: r = b;
      endcase
      return r;
    end
  endfunction

endpackage

`default_nettype wire

// ===== design/jsu_decode.sv =====
// Escape decoder: holds the escape state and turns one accepted byte into a burst
// of up to five output bytes. Depends on jsu_pkg.
`default_nettype none

module jsu_decode (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_fire,
  input  wire logic [7:0]      in_byte,
  input  wire logic            is_final,
  output jsu_pkg::burst_t      burst
);
  import jsu_pkg::*;

  mode_t            mode_r, mode_nxt;
  logic [11:0]      accum_r, accum_nxt;
  logic [2:0][7:0]  held_r;
  logic             held_we;
  logic [1:0]       k;
  logic [4:0]       hx;
  logic [15:0]      cp;
  logic             pass_bslash;

  assign k  = 2'(mode_r - MODE_U0);
  assign hx = hex_decode(in_byte);
  assign cp = {accum_r, hx[3:0]};
  assign pass_bslash = (in_byte == CH_BSLASH) && !is_final;

  always_comb begin
    mode_nxt    = mode_r;
    accum_nxt   = accum_r;
    held_we     = 1'b0;
    burst.bytes = '0;
    burst.cnt   = '0;
    burst.fin   = is_final;
    case (mode_r)
      MODE_ESC: begin
        mode_nxt = MODE_NORMAL;
        if (in_byte == CH_U && !is_final) begin
          mode_nxt  = MODE_U0;
          accum_nxt = '0;
        end else begin
          burst.bytes[0] = map_escape(in_byte);
          burst.cnt      = CntW'(1);
        end
      end
      MODE_U0, MODE_U1, MODE_U2, MODE_U3: begin
        if (hx[4] && k == 2'd3) begin
          mode_nxt  = MODE_NORMAL;
          accum_nxt = '0;
          if (cp[15:7] == '0) begin
            burst.bytes[0] = cp[7:0];
            burst.cnt      = CntW'(1);
          end else if (cp[15:11] == '0) begin
            burst.bytes[0] = UTF8_LEAD2 | {3'b000, cp[10:6]};
            burst.bytes[1] = UTF8_CONT | {2'b00, cp[5:0] & UTF8_MASK};
            burst.cnt      = CntW'(2);
          end else begin
            burst.bytes[0] = UTF8_LEAD3 | {4'h0, cp[15:12]};
            burst.bytes[1] = UTF8_CONT | {2'b00, cp[11:6] & UTF8_MASK};
            burst.bytes[2] = UTF8_CONT | {2'b00, cp[5:0] & UTF8_MASK};
            burst.cnt      = CntW'(3);
          end
        end else if (hx[4] && !is_final) begin
          held_we   = 1'b1;
          accum_nxt = {accum_r[7:0], hx[3:0]};
          mode_nxt  = mode_t'(mode_r + 3'd1);
        end else begin
          // malformed or cut short: replay 'u', held digits, non-backslash byte
          accum_nxt      = '0;
          burst.bytes[0] = CH_U;
          for (int i = 1; i < MaxResults - 1; i++) begin
            burst.bytes[i] = (i - 1 < int'(k)) ? held_r[i-1] : in_byte;
          end
          burst.bytes[MaxResults-1] = in_byte;
          if (pass_bslash) begin
            mode_nxt  = MODE_ESC;
            burst.cnt = CntW'({1'b0, k} + 3'd1);
          end else begin
            mode_nxt  = MODE_NORMAL;
            burst.cnt = CntW'({1'b0, k} + 3'd2);
          end
        end
      end
      default: begin
        if (pass_bslash) begin
          mode_nxt = MODE_ESC;
        end else begin
          mode_nxt       = MODE_NORMAL;
          burst.bytes[0] = in_byte;
          burst.cnt      = CntW'(1);
        end
      end
    endcase
    if (is_final) begin
      mode_nxt  = MODE_NORMAL;
      accum_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_NORMAL;
      accum_r <= '0;
    end else if (in_fire) begin
      mode_r  <= mode_nxt;
      accum_r <= accum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && held_we) begin
      for (int i = 0; i < 3; i++) begin
        if (k == 2'(i)) held_r[i] <= in_byte;
      end
    end
  end

  a_final_resets: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && is_final |=> mode_r == MODE_NORMAL && accum_r == '0)
    else $error("state not cleared after final byte");

  a_accum_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_NORMAL || mode_r == MODE_ESC || mode_r == MODE_U0) |-> accum_r == '0)
    else $error("code accumulator nonzero with no digits held");

  a_final_has_output: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && is_final |-> burst.cnt != '0)
    else $error("final byte produced no output");

endmodule

`default_nettype wire

// ===== design/jsu_burst.sv =====
// Result register: holds one burst and shifts it out one byte per handshake.
// Depends on jsu_pkg.
`default_nettype none

module jsu_burst (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_fire,
  input  jsu_pkg::burst_t      burst,
  output logic                 load_ok,
  output logic                 out_tvalid,
  input  wire logic            out_tready,
  output logic [7:0]           out_byte,
  output logic                 run_last,
  output logic                 string_end
);
  import jsu_pkg::*;

  logic [MaxResults-1:0][7:0] bytes_r;
  logic [CntW-1:0]            rem_r;
  logic                       fin_r;
  logic                       take;

  assign out_tvalid = (rem_r != '0);
  assign out_byte   = bytes_r[0];
  assign run_last   = (rem_r == CntW'(1));
  assign string_end = run_last && fin_r;
  assign take       = out_tvalid && out_tready;
  assign load_ok    = (rem_r == '0) || (run_last && out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= '0;
    end else if (in_fire) begin
      rem_r <= burst.cnt;
    end else if (take) begin
      rem_r <= rem_r - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      bytes_r <= burst.bytes;
      fin_r   <= burst.fin;
    end else if (take) begin
      bytes_r <= {8'h00, bytes_r[MaxResults-1:1]};
    end
  end

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rem_r <= CntW'(MaxResults))
    else $error("burst count out of range");

  a_rem_step: assert property (@(posedge clk) disable iff (!rst_n)
    take && rem_r > CntW'(1) |=> rem_r == $past(rem_r) - CntW'(1))
    else $error("burst count did not step down");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |-> rem_r == '0 || (take && run_last))
    else $error("new item loaded over pending output");

endmodule

`default_nettype wire

// ===== design/json_string_unescape.sv =====
// JSON string unescaper: one raw byte of a string body per input item, one
// unescaped byte per output item. Handles the single-character escapes and
// \uXXXX (to 1-3 bytes of UTF-8); malformed or cut-short \u sequences are
// replayed as 'u' and the held digits. Items that yield zero or one output
// byte stream at one per clock while out_tready is high; an item with more
// (up to five) holds off the next input until its last byte is handed off,
// as the one output register shifts its burst out one byte per handshake.
// The last byte of each item's burst carries out_tlast; the last byte of
// a string also out_tuser. Depends on jsu_pkg, jsu_decode, jsu_burst.
`default_nettype none

module json_string_unescape (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] in_byte
  input  wire logic       in_tlast,   // is_final
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,  // [7:0] out_byte
  output logic            out_tlast,  // run_last
  output logic [0:0]      out_tuser   // [0] string_end
);
  import jsu_pkg::*;

  burst_t burst;
  logic   in_fire;
  logic   string_end;

  assign in_fire   = in_tvalid && in_tready;
  assign out_tuser = string_end;

  jsu_decode u_decode (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .in_byte  (in_tdata),
    .is_final (in_tlast),
    .burst    (burst)
  );

  jsu_burst u_burst (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_fire    (in_fire),
    .burst      (burst),
    .load_ok    (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_byte   (out_tdata),
    .run_last   (out_tlast),
    .string_end (string_end)
  );

endmodule

`default_nettype wire
